// ----- rtl/b2da_pkg.sv -----
package b2da_pkg;

  // Field widths
  localparam int VALUE_W = 32;
  localparam int CHAR_W  = 6;
  localparam int DIGIT_W = 4;

  // Default number of BCD digit positions
  localparam int MAX_DIGITS_DEF = 10;

  // Shift counter for the conversion, holds VALUE_W itself
  localparam int SHIFT_CNT_W = $clog2(VALUE_W + 1);

  // ASCII '0', trimmed to the character width
  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  // Adjust threshold of the double-dabble step
  localparam logic [DIGIT_W-1:0] ADJ_LIMIT = DIGIT_W'(5);
  localparam logic [DIGIT_W-1:0] ADJ_ADD   = DIGIT_W'(3);

  // Status from the converter to the top level
  typedef struct packed {
    logic busy;
    logic done;
  } conv_stat_t;

endpackage

// ----- rtl/b2da_dabble.sv -----
module b2da_dabble #(
  parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   load,
  input  logic [b2da_pkg::VALUE_W-1:0]           value,
  output logic [MAX_DIGITS*b2da_pkg::DIGIT_W-1:0] bcd,
  output b2da_pkg::conv_stat_t                   stat
);
  import b2da_pkg::*;

  localparam int BCD_W = MAX_DIGITS * DIGIT_W;

  logic [VALUE_W-1:0]     bin;
  logic [BCD_W-1:0]       bcd_adj;
  logic [SHIFT_CNT_W-1:0] cnt;
  logic                   done;

  // Add three to every digit of five or more, all digits at once
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= ADJ_LIMIT) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + ADJ_ADD;
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // One binary bit into the BCD register per cycle; the top digit's
  // carry falls off, which leaves the value modulo 10^MAX_DIGITS
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (load) begin
        cnt <= SHIFT_CNT_W'(VALUE_W);
        bin <= value;
        bcd <= '0;
      end else if (cnt != '0) begin
        bcd  <= {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
        bin  <= {bin[VALUE_W-2:0], 1'b0};
        cnt  <= cnt - 1'b1;
        done <= (cnt == SHIFT_CNT_W'(1));
      end
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = done;

endmodule

// ----- rtl/b2da_emit.sv -----
module b2da_emit #(
  parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    load,
  input  logic [MAX_DIGITS*b2da_pkg::DIGIT_W-1:0] bcd,
  output logic                                    active,
  output logic                                    strobe,
  output logic [b2da_pkg::CHAR_W-1:0]             digit_char,
  output logic                                    last_digit
);
  import b2da_pkg::*;

  localparam int BCD_W = MAX_DIGITS * DIGIT_W;
  localparam int REM_W = $clog2(MAX_DIGITS + 1);

  logic [BCD_W-1:0]   sh;
  logic [REM_W-1:0]   remain;
  logic               seen;
  logic [DIGIT_W-1:0] top_digit;
  logic               at_last;
  logic               emit;

  // Top digit of the shift register, and whether it goes out
  assign top_digit = sh[BCD_W-1 -: DIGIT_W];
  assign at_last   = (remain == REM_W'(1));
  assign emit      = seen | (top_digit != '0) | at_last;

  // One digit per cycle from the top; leading zeros are skipped, but the last digit always goes out
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
      remain <= '0;
      seen   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (load) begin
        active <= 1'b1;
        sh     <= bcd;
        remain <= REM_W'(MAX_DIGITS);
        seen   <= 1'b0;
      end else if (active) begin
        strobe     <= emit;
        digit_char <= ASCII_ZERO + CHAR_W'(top_digit);
        last_digit <= at_last;
        sh         <= sh << DIGIT_W;
        remain     <= remain - 1'b1;
        seen       <= emit;
        if (at_last) begin
          active <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- rtl/binary_to_decimal_ascii.sv -----
// Channel   Ports                                  Handshake
// input     value                                  start & !busy at the clock edge
// result    digit_char, last_digit                 digit_valid, one cycle per item
//
// An item is taken in, its bits are shifted into the BCD register by
// double-dabble (one bit per cycle), it is handed over to the read-out, and the
// BCD register is read out one digit per cycle from the top; leading zeros are
// read out too but give no result. busy drops as the last digit shows, so a new
// item is only taken once the last one is through. Reset (synchronous) drops any
// item in flight. The receiver cannot stall: every result is shown for
// exactly one cycle.
module binary_to_decimal_ascii #(
  parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [b2da_pkg::VALUE_W-1:0]    value,
  output logic                            digit_valid,
  output logic [b2da_pkg::CHAR_W-1:0]     digit_char,
  output logic                            last_digit
);
  import b2da_pkg::*;

  logic                          accept;
  logic [MAX_DIGITS*DIGIT_W-1:0] bcd;
  conv_stat_t                    conv_stat;
  logic                          emit_active;

  assign accept = start & ~busy;
  assign busy   = conv_stat.busy | conv_stat.done | emit_active;

  // Binary to BCD conversion
  b2da_dabble #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dabble (
    .clk   (clk),
    .rst   (rst),
    .load  (accept),
    .value (value),
    .bcd   (bcd),
    .stat  (conv_stat)
  );

  // Digit serialiser
  b2da_emit #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (conv_stat.done),
    .bcd        (bcd),
    .active     (emit_active),
    .strobe     (digit_valid),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

  // Every character is an ASCII digit
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    digit_valid |-> (digit_char >= ASCII_ZERO) && (digit_char <= ASCII_ZERO + CHAR_W'(9)))
    else $error("digit character out of range");

  // An accepted item keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !digit_valid)
    else $error("block not busy after accept");

  // A run only ends on its last digit
  a_run_open: assert property (@(posedge clk) disable iff (rst)
    digit_valid && !last_digit |-> busy)
    else $error("run closed before its last digit");

  // Conversion and read-out never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(conv_stat.busy && emit_active))
    else $error("conversion and read-out overlap");

endmodule
